[rtl/bqc_pkg.sv]
package bqc_pkg;

    localparam int SAMPLE_W = 24;
    localparam int COEF_W   = 20;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int ACC_W    = PROD_W + 4;
    localparam int HIST_W   = 4 * SAMPLE_W;
    localparam int CH_W     = 2;
    localparam int SEC_CFG_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int TDATA_W  = 32;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7fffff;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_B0       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B1       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B2       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_A1       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_A2       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SECTIONS = 3'd7;

    // product terms of one section, in issue order
    localparam logic [2:0] TERM_B0 = 3'd0;
    localparam logic [2:0] TERM_B1 = 3'd1;
    localparam logic [2:0] TERM_B2 = 3'd2;
    localparam logic [2:0] TERM_A1 = 3'd3;
    localparam logic [2:0] TERM_A2 = 3'd4;

    typedef struct packed {
        logic signed [COEF_W-1:0]   b0;
        logic signed [COEF_W-1:0]   b1;
        logic signed [COEF_W-1:0]   b2;
        logic signed [COEF_W-1:0]   a1;
        logic signed [COEF_W-1:0]   a2;
        logic signed [SAMPLE_W-1:0] out_min;
        logic signed [SAMPLE_W-1:0] out_max;
    } t_cfg;

    typedef struct packed {
        logic       load;
        logic       rd_en;
        logic       acc_clr;
        logic       mac_en;
        logic [2:0] term;
        logic       wb;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_sts;

endpackage

[rtl/bqc_ram.sv]
module bqc_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/bqc_ctrl.sv]
module bqc_ctrl #(
    parameter int MAX_SECTIONS = 4,
    localparam int SIW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [bqc_pkg::SEC_CFG_W-1:0]  i_sections,
    input  bqc_pkg::t_sts                  i_sts,
    output bqc_pkg::t_cmd                  o_cmd,
    output logic [SIW-1:0]                 o_sect
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MAC,
        S_DRAIN,
        S_WB,
        S_OUT
    } t_state;

    t_state         r_state;
    logic [SIW-1:0] r_sect;
    logic [2:0]     r_term;
    logic [4:0]     ns;
    logic           last_sect;
    logic           accept;

    // section count limited to what the history store holds
    assign ns = (5'(i_sections) > 5'(MAX_SECTIONS)) ? 5'(MAX_SECTIONS) : 5'(i_sections);
    assign last_sect = (5'(r_sect) == (ns - 5'd1));
    assign o_in_ready = (r_state == S_IDLE);
    assign accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sect  <= '0;
            r_term  <= bqc_pkg::TERM_B0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_sect <= '0;
                    if (accept) begin
                        r_state <= (ns == 5'd0) ? S_OUT : S_READ;
                    end
                end
                S_READ: begin
                    r_term  <= bqc_pkg::TERM_B0;
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    if (r_term == bqc_pkg::TERM_A2) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_term <= r_term + 3'd1;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_WB;
                end
                S_WB: begin
                    if (last_sect) begin
                        r_state <= S_OUT;
                    end else begin
                        r_sect  <= r_sect + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_OUT: begin
                    if (!i_sts.out_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = accept;
        o_cmd.rd_en    = (r_state == S_READ);
        o_cmd.acc_clr  = (r_state == S_READ);
        o_cmd.mac_en   = (r_state == S_MAC);
        o_cmd.term     = r_term;
        o_cmd.wb       = (r_state == S_WB);
        o_cmd.out_load = (r_state == S_OUT) && !i_sts.out_busy;
    end

    assign o_sect = r_sect;

endmodule

[rtl/bqc_datapath.sv]
module bqc_datapath #(
    parameter int CHANNELS = 4,
    parameter int MAX_SECTIONS = 4,
    localparam int SIW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bqc_pkg::t_cfg                   i_cfg,
    input  bqc_pkg::t_cmd                   i_cmd,
    input  logic [SIW-1:0]                  i_sect,
    output bqc_pkg::t_sts                   o_sts,
    input  logic [bqc_pkg::CH_W-1:0]        i_channel,
    input  logic signed [bqc_pkg::SAMPLE_W-1:0] i_sample,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [bqc_pkg::CH_W-1:0]        o_channel,
    output logic signed [bqc_pkg::SAMPLE_W-1:0] o_sample
);

    localparam int SW    = bqc_pkg::SAMPLE_W;
    localparam int DEPTH = CHANNELS * MAX_SECTIONS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // channel number folded onto the channels that have history
    function automatic logic [CW-1:0] ch_fold(input logic [bqc_pkg::CH_W-1:0] c);
        logic [4:0] v;
        v = 5'(c);
        for (int i = 0; i < 3; i++) begin
            if (v >= 5'(CHANNELS)) begin
                v = v - 5'(CHANNELS);
            end
        end
        return v[CW-1:0];
    endfunction

    logic [bqc_pkg::CH_W-1:0]           r_ch_in;
    logic [8:0]                         r_base;
    logic signed [SW-1:0]               r_x;
    logic [DEPTH-1:0]                   r_hvalid;
    logic                               r_rd_valid;
    logic signed [bqc_pkg::PROD_W-1:0]  r_prod;
    logic                               r_prod_vld;
    logic                               r_prod_neg;
    logic signed [bqc_pkg::ACC_W-1:0]   r_acc;
    logic                               r_ovalid;
    logic [bqc_pkg::CH_W-1:0]           r_och;
    logic signed [SW-1:0]               r_osample;

    logic [8:0]                         addr_full;
    logic [AW-1:0]                      addr;
    logic [bqc_pkg::HIST_W-1:0]         rdata;
    logic [bqc_pkg::HIST_W-1:0]         hist;
    logic [bqc_pkg::HIST_W-1:0]         wdata;
    logic signed [SW-1:0]               h_x1, h_x2, h_y1;
    logic signed [SW-1:0]               h_y2;
    logic signed [bqc_pkg::COEF_W-1:0]  coef;
    logic signed [SW-1:0]               opnd;
    logic signed [bqc_pkg::ACC_W-1:0]   rnd;
    logic signed [bqc_pkg::ACC_W-17:0]  q;
    logic signed [SW-1:0]               y_sat;
    logic signed [SW-1:0]               clipped;

    assign addr_full = r_base + 9'(i_sect);
    assign addr      = addr_full[AW-1:0];

    bqc_ram #(
        .WIDTH (bqc_pkg::HIST_W),
        .DEPTH (DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wb),
        .i_waddr (addr),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (addr),
        .o_rdata (rdata)
    );

    // never-written entries read as zero history
    assign hist = r_rd_valid ? rdata : '0;
    assign h_x1 = hist[SW-1:0];
    assign h_x2 = hist[2*SW-1:SW];
    assign h_y1 = hist[3*SW-1:2*SW];
    assign h_y2 = hist[4*SW-1:3*SW];

    always_comb begin
        case (i_cmd.term)
            bqc_pkg::TERM_B0: begin coef = i_cfg.b0; opnd = r_x;  end
            bqc_pkg::TERM_B1: begin coef = i_cfg.b1; opnd = h_x1; end
            bqc_pkg::TERM_B2: begin coef = i_cfg.b2; opnd = h_x2; end
            bqc_pkg::TERM_A1: begin coef = i_cfg.a1; opnd = h_y1; end
            bqc_pkg::TERM_A2: begin coef = i_cfg.a2; opnd = h_y2; end
            default:          begin coef = '0;       opnd = '0;   end
        endcase
    end

    // round half up to Q15.8, then saturate
    assign rnd = r_acc + bqc_pkg::ACC_W'(32768);
    assign q   = rnd[bqc_pkg::ACC_W-1:16];

    always_comb begin
        if (q > (bqc_pkg::ACC_W-16)'(bqc_pkg::SAMPLE_MAX)) begin
            y_sat = bqc_pkg::SAMPLE_MAX;
        end else if (q < (bqc_pkg::ACC_W-16)'(bqc_pkg::SAMPLE_MIN)) begin
            y_sat = bqc_pkg::SAMPLE_MIN;
        end else begin
            y_sat = q[SW-1:0];
        end
    end

    assign wdata = {h_y1, y_sat, h_x1, r_x};

    // with inverted limits, samples below out_min give out_min and all others give out_max
    always_comb begin
        if (r_x < i_cfg.out_min) begin
            clipped = i_cfg.out_min;
        end else if (r_x > i_cfg.out_max) begin
            clipped = i_cfg.out_max;
        end else begin
            clipped = r_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ch_in <= i_channel;
            r_base  <= 9'(ch_fold(i_channel)) * 9'(MAX_SECTIONS);
            r_x     <= i_sample;
        end else if (i_cmd.wb) begin
            r_x <= y_sat;
        end
        if (i_cmd.rd_en) begin
            r_rd_valid <= r_hvalid[addr];
        end
        if (i_cmd.mac_en) begin
            r_prod     <= coef * opnd;
            r_prod_neg <= (i_cmd.term == bqc_pkg::TERM_A1) ||
                          (i_cmd.term == bqc_pkg::TERM_A2);
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            if (r_prod_neg) begin
                r_acc <= r_acc - bqc_pkg::ACC_W'(r_prod);
            end else begin
                r_acc <= r_acc + bqc_pkg::ACC_W'(r_prod);
            end
        end
        if (i_cmd.out_load) begin
            r_och     <= r_ch_in;
            r_osample <= clipped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hvalid   <= '0;
            r_prod_vld <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_prod_vld <= i_cmd.mac_en;
            if (i_cmd.wb) begin
                r_hvalid[addr] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_sts.out_busy = r_ovalid && !i_ready;
    assign o_valid   = r_ovalid;
    assign o_channel = r_och;
    assign o_sample  = r_osample;

endmodule

[rtl/biquad_cascade_filter_unit.sv]
// Multi-channel cascaded biquad filter, direct form I, fixed point.
// Input stream (s_axis_*): one beat carries a channel number and a Q15.8
// sample. Output stream (m_axis_*): one beat per input beat, in order, with
// the same channel number and the filtered sample clipped to out_min/out_max.
// Configuration channel (i_cfg_*): index 0..7 selects b0, b1, b2, a1, a2,
// out_min, out_max, sections_in_use; always ready, write only while idle.
// Timing: a sample is taken only when the filter is idle, so the next sample is
// not accepted before the last one is through. Each section runs on the single
// shared multiply-accumulate unit as history read, five products, pipeline
// drain, round and write back.
// The result sits in an output register: the next sample is accepted while it
// waits, and a stalled receiver only holds the filter once the next result is
// ready to be loaded.
// Reset sets the coefficients and limits to their defaults and marks all
// filter history as zero at once; no clearing pass is needed.
module biquad_cascade_filter_unit #(
    parameter int CHANNELS = 4,
    parameter int MAX_SECTIONS = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [1:0] channel, [25:2] sample_in, [31:26] zero
    input  logic [bqc_pkg::TDATA_W-1:0]       s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [1:0] channel_out, [25:2] sample_out, [31:26] zero
    output logic [bqc_pkg::TDATA_W-1:0]       m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bqc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bqc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int SIW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int CH_W = bqc_pkg::CH_W;
    localparam int SW = bqc_pkg::SAMPLE_W;

    bqc_pkg::t_cfg                 r_cfg;
    logic [bqc_pkg::SEC_CFG_W-1:0] r_sections;
    bqc_pkg::t_cmd                 cmd;
    bqc_pkg::t_sts                 sts;
    logic [SIW-1:0]                sect;
    logic [CH_W-1:0]               out_ch;
    logic signed [SW-1:0]          out_sample;
    logic                          cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.b0      <= 20'sd10923;
            r_cfg.b1      <= 20'sd10923;
            r_cfg.b2      <= '0;
            r_cfg.a1      <= -20'sd43691;
            r_cfg.a2      <= '0;
            r_cfg.out_min <= -24'sd46080;
            r_cfg.out_max <= 24'sd46080;
            r_sections    <= 3'd1;
        end else if (cfg_we) begin
            case (i_cfg_index)
                bqc_pkg::REG_B0:       r_cfg.b0 <= i_cfg_data[bqc_pkg::COEF_W-1:0];
                bqc_pkg::REG_B1:       r_cfg.b1 <= i_cfg_data[bqc_pkg::COEF_W-1:0];
                bqc_pkg::REG_B2:       r_cfg.b2 <= i_cfg_data[bqc_pkg::COEF_W-1:0];
                bqc_pkg::REG_A1:       r_cfg.a1 <= i_cfg_data[bqc_pkg::COEF_W-1:0];
                bqc_pkg::REG_A2:       r_cfg.a2 <= i_cfg_data[bqc_pkg::COEF_W-1:0];
                bqc_pkg::REG_OUT_MIN:  r_cfg.out_min <= i_cfg_data[SW-1:0];
                bqc_pkg::REG_OUT_MAX:  r_cfg.out_max <= i_cfg_data[SW-1:0];
                bqc_pkg::REG_SECTIONS: r_sections <= i_cfg_data[bqc_pkg::SEC_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    bqc_ctrl #(
        .MAX_SECTIONS (MAX_SECTIONS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sections (r_sections),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_sect     (sect)
    );

    bqc_datapath #(
        .CHANNELS     (CHANNELS),
        .MAX_SECTIONS (MAX_SECTIONS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_cmd     (cmd),
        .i_sect    (sect),
        .o_sts     (sts),
        .i_channel (s_axis_tdata[CH_W-1:0]),
        .i_sample  (s_axis_tdata[CH_W+SW-1:CH_W]),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_channel (out_ch),
        .o_sample  (out_sample)
    );

    assign m_axis_tdata = {(bqc_pkg::TDATA_W-CH_W-SW)'(0), out_sample, out_ch};

endmodule
